@@ hw/rtl/coalescing_update_queue_assert.svh @@
// Assertion macros for the coalescing update queue.
`ifndef COALESCING_UPDATE_QUEUE_ASSERT_SVH
`define COALESCING_UPDATE_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define CUQ_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CUQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define CUQ_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define CUQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

@@ hw/rtl/cuq_pkg.sv @@
// ----------------------------------------------------------------------------
// cuq_pkg
// Types and constants shared by the coalescing update queue.
// ----------------------------------------------------------------------------
package cuq_pkg;
    localparam int unsigned DefEntries   = 16;
    localparam int unsigned DefKeyBits   = 16;
    localparam int unsigned DefValueBits = 32;
    localparam int unsigned KeyPortBits  = 16;
    localparam int unsigned ValPortBits  = 32;
    localparam int unsigned StampBits    = 32;

    typedef enum logic [2:0] {
        ST_PUSHED   = 3'd0,
        ST_MERGED   = 3'd1,
        ST_POPPED   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PUSH_WR,
        S_POP_RD,
        S_POP_RD2,
        S_DONE
    } t_state;
endpackage

@@ hw/rtl/coalescing_update_queue.sv @@
// ----------------------------------------------------------------------------
// coalescing_update_queue
// Keyed FIFO that merges pushes to a key that is already queued.
// ----------------------------------------------------------------------------
// Usage: raise i_start with i_kind (0 push, 1 pop) and the payload while
// o_busy is low; the item is taken at that edge and o_busy rises.
// Exactly one result follows, shown for one cycle with o_valid high:
// o_status, o_out_key/o_out_value/o_out_stamp (popped data, else zero)
// and o_now_empty. The receiver cannot stall; the result is simply shown.
// Flow: a push scans the key memory one slot a cycle, then writes the
// chosen slot; a merge ends as soon as the matching slot is read. A pop
// reads the order ring, then the data memories, and shows its result
// from the registered read data. The next item may be started in the
// cycle the result shows.
// Reset clears the used bits, the ring pointers and the count; the data
// memories are not cleared, as the data of unused slots is never used.
// ----------------------------------------------------------------------------
`include "coalescing_update_queue_assert.svh"

module coalescing_update_queue
    import cuq_pkg::*;
#(
    parameter int unsigned ENTRIES    = DefEntries,
    parameter int unsigned KEY_BITS   = DefKeyBits,
    parameter int unsigned VALUE_BITS = DefValueBits
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_kind,
    input  logic [KeyPortBits-1:0] i_key_tag,
    input  logic [ValPortBits-1:0] i_new_value,
    input  logic [StampBits-1:0]   i_stamp,
    output logic                   o_valid,
    output logic [2:0]             o_status,
    output logic [KeyPortBits-1:0] o_out_key,
    output logic [ValPortBits-1:0] o_out_value,
    output logic [StampBits-1:0]   o_out_stamp,
    output logic                   o_now_empty
);
    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [ENTRIES];
    logic [StampBits-1:0]  stamp_mem [ENTRIES];
    logic [IW-1:0]         ring_mem  [ENTRIES];

    t_state r_state, n_state;
    logic [ENTRIES-1:0] r_used;
    logic [IW-1:0] r_head, r_tail;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_scan;
    logic [IW-1:0] r_free;
    logic          r_have_free;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [StampBits-1:0]  r_stp;
    logic [IW-1:0] r_slot;
    logic [KEY_BITS-1:0]   r_key_rd;
    logic [VALUE_BITS-1:0] r_val_rd;
    logic [StampBits-1:0]  r_stp_rd;
    logic [IW-1:0] r_ring_rd;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_vld;
    logic [2:0]    r_res_status;
    logic          r_res_valid;

    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_val;
    logic                  accept;
    logic                  hit;
    logic                  scan_last;

    // widen or cut the port fields to the stored widths
    always_comb begin
        in_key = '0;
        in_val = '0;
        for (int b = 0; b < KEY_BITS; b++) begin
            if (b < KeyPortBits) begin
                in_key[b] = i_key_tag[b];
            end
        end
        for (int b = 0; b < VALUE_BITS; b++) begin
            if (b < ValPortBits) begin
                in_val[b] = i_new_value[b];
            end
        end
    end

    assign accept    = i_start && !o_busy;
    assign hit       = r_rd_vld && r_used[r_rd_idx] && (r_key_rd == r_key);
    assign scan_last = (r_scan == CW'(ENTRIES));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE, S_DONE: begin
                if (accept) begin
                    n_state = i_kind ? S_POP_RD : S_SEARCH;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (hit || (scan_last && !r_rd_vld)) begin
                    n_state = S_PUSH_WR;
                end
            end
            S_PUSH_WR: n_state = S_DONE;
            S_POP_RD:  n_state = S_POP_RD2;
            S_POP_RD2: n_state = S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy  = !(r_state == S_IDLE || r_state == S_DONE);
        o_valid = r_res_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_scan      <= '0;
            r_rd_vld    <= 1'b0;
            r_res_valid <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= (r_state == S_PUSH_WR) || (r_state == S_POP_RD2);
            if (accept) begin
                r_key       <= in_key;
                r_val       <= in_val;
                r_stp       <= i_stamp;
                r_scan      <= '0;
                r_rd_vld    <= 1'b0;
                r_have_free <= 1'b0;
            end
            case (r_state)
                S_SEARCH: begin
                    // one read per cycle; compare the slot read last cycle
                    if (hit) begin
                        r_slot       <= r_rd_idx;
                        r_scan       <= CW'(ENTRIES);
                        r_rd_vld     <= 1'b0;
                        r_res_status <= ST_MERGED;
                    end else begin
                        if (!scan_last) begin
                            r_rd_idx <= r_scan[IW-1:0];
                            r_rd_vld <= 1'b1;
                            r_scan   <= r_scan + CW'(1);
                        end else begin
                            r_rd_vld <= 1'b0;
                        end
                        if (r_rd_vld && !r_used[r_rd_idx] && !r_have_free) begin
                            r_free      <= r_rd_idx;
                            r_have_free <= 1'b1;
                        end
                        if (scan_last && !r_rd_vld) begin
                            r_slot       <= r_free;
                            r_res_status <= r_have_free ? ST_PUSHED : ST_FULL;
                        end
                    end
                end
                S_PUSH_WR: begin
                    if (r_res_status == ST_PUSHED) begin
                        r_used[r_slot] <= 1'b1;
                        r_tail  <= (r_tail == IW'(ENTRIES - 1)) ? '0 : r_tail + IW'(1);
                        r_count <= r_count + CW'(1);
                    end
                end
                S_POP_RD: begin
                    r_res_status <= (r_count == '0) ? ST_EMPTY : ST_POPPED;
                end
                S_POP_RD2: begin
                    if (r_res_status == ST_POPPED) begin
                        r_used[r_ring_rd] <= 1'b0;
                        r_head  <= (r_head == IW'(ENTRIES - 1)) ? '0 : r_head + IW'(1);
                        r_count <= r_count - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // memories: one read port each, registered read data
    always_ff @(posedge i_clk) begin
        if (r_state == S_SEARCH && !scan_last) begin
            r_key_rd <= key_mem[r_scan[IW-1:0]];
        end
        if (r_state == S_POP_RD) begin
            r_ring_rd <= ring_mem[r_head];
        end
        if (r_state == S_POP_RD2) begin
            r_key_rd <= key_mem[r_ring_rd];
            r_val_rd <= value_mem[r_ring_rd];
            r_stp_rd <= stamp_mem[r_ring_rd];
        end
        if (r_state == S_PUSH_WR &&
            (r_res_status == ST_PUSHED || r_res_status == ST_MERGED)) begin
            value_mem[r_slot] <= r_val;
            stamp_mem[r_slot] <= r_stp;
            if (r_res_status == ST_PUSHED) begin
                key_mem[r_slot]  <= r_key;
                ring_mem[r_tail] <= r_slot;
            end
        end
    end

    // result ports
    always_comb begin
        o_status    = r_res_status;
        o_out_key   = '0;
        o_out_value = '0;
        o_out_stamp = '0;
        o_now_empty = (r_count == '0);
        if (r_res_status == ST_POPPED) begin
            for (int b = 0; b < KeyPortBits; b++) begin
                if (b < KEY_BITS) begin
                    o_out_key[b] = r_key_rd[b];
                end
            end
            for (int b = 0; b < ValPortBits; b++) begin
                if (b < VALUE_BITS) begin
                    o_out_value[b] = r_val_rd[b];
                end
            end
            o_out_stamp = r_stp_rd;
        end
    end

    `CUQ_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, r_count <= CW'(ENTRIES), "count overflow")
    `CUQ_ASSERT_IMPL(a_count_used, i_clk, i_rst_n, r_count == CW'($countones(r_used)), "count mismatch")
    `CUQ_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, accept, o_busy, "no busy after start")
endmodule
